### rtl/sd_card_spi_host_engine_top_assert.svh
// Assertion macros for the SPI host engine.
`ifndef SD_CARD_SPI_HOST_ENGINE_TOP_ASSERT_SVH
`define SD_CARD_SPI_HOST_ENGINE_TOP_ASSERT_SVH
// Same-cycle implication, ignored during reset.
`define SDH_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sdh assertion failed");
// Next-cycle implication, ignored during reset.
`define SDH_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sdh assertion failed");
// Next-cycle implication, checked at every edge, reset included.
`define SDH_ASSERT_ALWAYS(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("sdh assertion failed");
`endif

### rtl/sdh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package sdh_pkg;
   localparam int SECTOR_BYTES_DEFAULT = 512;
   localparam logic [15:0] ATTEMPT_LIMIT_RESET = 16'd10000;
   localparam logic [3:0]  BLOCK_LOG2_RESET    = 4'd9;

   localparam logic [2:0] ACT_INIT  = 3'd0;
   localparam logic [2:0] ACT_READ  = 3'd1;
   localparam logic [2:0] ACT_WRITE = 3'd2;
   localparam logic [2:0] ACT_LOAD  = 3'd3;
   localparam logic [2:0] ACT_CARD  = 3'd4;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_NO_IDLE   = 3'd1;
   localparam logic [2:0] ST_REJECTED  = 3'd2;
   localparam logic [2:0] ST_INIT_TOUT = 3'd3;
   localparam logic [2:0] ST_SIZE_BAD  = 3'd4;
   localparam logic [2:0] ST_TOKEN_ERR = 3'd5;
   localparam logic [2:0] ST_NOT_READY = 3'd6;

   localparam logic [0:0] CSR_ATTEMPT_LIMIT = 1'd0;
   localparam logic [0:0] CSR_BLOCK_LOG2    = 1'd1;

   localparam logic [7:0] BYTE_IDLE  = 8'hFF;
   localparam logic [7:0] TOKEN_DATA = 8'hFE;

   typedef enum logic [17:0] {
      PH_IDLE      = 18'h00001,
      PH_WAKE      = 18'h00002,
      PH_CMD0      = 18'h00004,
      PH_CMD8      = 18'h00008,
      PH_CMD8_TAIL = 18'h00010,
      PH_CMD55     = 18'h00020,
      PH_ACMD41    = 18'h00040,
      PH_CMD9      = 18'h00080,
      PH_CSD_TOKEN = 18'h00100,
      PH_CSD_DATA  = 18'h00200,
      PH_CMD17     = 18'h00400,
      PH_RD_TOKEN  = 18'h00800,
      PH_RD_DATA   = 18'h01000,
      PH_RD_CRC    = 18'h02000,
      PH_CMD24     = 18'h04000,
      PH_WR_DATA   = 18'h08000,
      PH_WR_RESP   = 18'h10000,
      PH_WR_BUSY   = 18'h20000
   } phase_type;

   typedef struct packed {
      logic [7:0] mosi_byte;
      logic       mosi_valid;
      logic       select_low;
      logic [7:0] read_byte;
      logic       read_valid;
      logic       done_res;
      logic [2:0] status;
      logic [7:0] card_response;
   } result_type;

   function automatic logic [7:0] frame_byte(phase_type p, logic [2:0] k,
                                             logic [31:0] sec);
      logic [5:0]  code;
      logic [31:0] arg;
      logic [7:0]  crc;
      code = 6'd24;
      arg  = sec;
      crc  = BYTE_IDLE;
      unique case (p)
         PH_CMD0: begin
            code = 6'd0; arg = 32'd0; crc = 8'h95;
         end
         PH_CMD8: begin
            code = 6'd8; arg = 32'h0000_01AA; crc = 8'h87;
         end
         PH_CMD55: begin
            code = 6'd55; arg = 32'd0;
         end
         PH_ACMD41: begin
            code = 6'd41; arg = 32'h4000_0000;
         end
         PH_CMD9: begin
            code = 6'd9; arg = 32'd0;
         end
         PH_CMD17: begin
            code = 6'd17;
         end
         default: begin
            code = 6'd24;
         end
      endcase
      case (k)
         3'd0:    frame_byte = {2'b01, code};
         3'd1:    frame_byte = arg[31:24];
         3'd2:    frame_byte = arg[23:16];
         3'd3:    frame_byte = arg[15:8];
         3'd4:    frame_byte = arg[7:0];
         default: frame_byte = crc;
      endcase
   endfunction
endpackage
`default_nettype wire

### rtl/sdh_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module sdh_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

### rtl/sdh_seq.sv
`timescale 1ns / 1ps
`default_nettype none
module sdh_seq #(
   parameter int SECTOR_BYTES = sdh_pkg::SECTOR_BYTES_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            accept,
   input  wire logic [2:0]                      action,
   input  wire logic [7:0]                      drive_index,
   input  wire logic [31:0]                     sector_address,
   input  wire logic [7:0]                      sector_count,
   input  wire logic [7:0]                      data_byte,
   input  wire logic [15:0]                     attempt_limit,
   input  wire logic [3:0]                      block_size_log2,
   input  wire logic [7:0]                      buf_rd_data,
   output logic                                 buf_wr_en,
   output logic      [$clog2(SECTOR_BYTES)-1:0] buf_wr_addr,
   output logic      [7:0]                      buf_wr_data,
   output logic      [$clog2(SECTOR_BYTES)-1:0] buf_rd_addr,
   output logic                                 res_valid,
   output sdh_pkg::result_type                  res
);
   localparam int CW = $clog2(SECTOR_BYTES + 1);
   localparam int AW = $clog2(SECTOR_BYTES);
   localparam logic [CW-1:0] LAST = CW'(SECTOR_BYTES - 1);
   localparam logic [CW-1:0] FULL = CW'(SECTOR_BYTES);

   sdh_pkg::phase_type ph_ff, ph_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [15:0]   att_ff, att_in;
   logic [31:0]   sec_ff, sec_in;
   logic [7:0]    left_ff, left_in;
   logic          ready_ff, ready_in;
   logic          sel_ff, sel_in;
   logic          bad_ff, bad_in;
   logic [7:0]    resp_ff, resp_in;

   logic          emit_v, fin_v, rv;
   logic [7:0]    emit_b, rd_b;
   logic [2:0]    fin_s;
   logic [15:0]   att_dec, reload_val;
   logic          spend_ok;
   logic [7:0]    d;

   assign d          = data_byte;
   assign att_dec    = (att_ff != 16'd0) ? att_ff - 16'd1 : 16'd0;
   assign spend_ok   = att_dec != 16'd0;
   assign reload_val = (attempt_limit == 16'd0) ? 16'd1 : attempt_limit;

   always_comb begin
      ph_in = ph_ff; cnt_in = cnt_ff; att_in = att_ff; sec_in = sec_ff;
      left_in = left_ff; ready_in = ready_ff; sel_in = sel_ff; bad_in = bad_ff;
      resp_in = resp_ff;
      emit_v = 1'b0; emit_b = 8'd0; fin_v = 1'b0; fin_s = sdh_pkg::ST_OK;
      rv = 1'b0; rd_b = 8'd0;
      buf_wr_en = 1'b0;
      if (accept && action == sdh_pkg::ACT_CARD && ph_ff != sdh_pkg::PH_IDLE) begin
         unique case (ph_ff)
            sdh_pkg::PH_WAKE: begin
               if (cnt_ff < CW'(9)) begin
                  cnt_in = cnt_ff + CW'(1); emit_v = 1'b1; emit_b = sdh_pkg::BYTE_IDLE;
               end else begin
                  att_in = reload_val; ph_in = sdh_pkg::PH_CMD0; cnt_in = '0;
                  sel_in = 1'b1; emit_v = 1'b1;
                  emit_b = sdh_pkg::frame_byte(sdh_pkg::PH_CMD0, 3'd0, sec_ff);
               end
            end
            sdh_pkg::PH_CMD0, sdh_pkg::PH_CMD8, sdh_pkg::PH_CMD55, sdh_pkg::PH_ACMD41,
            sdh_pkg::PH_CMD9, sdh_pkg::PH_CMD17, sdh_pkg::PH_CMD24: begin
               if (cnt_ff < CW'(5)) begin
                  cnt_in = cnt_ff + CW'(1); emit_v = 1'b1;
                  emit_b = sdh_pkg::frame_byte(ph_ff, cnt_in[2:0], sec_ff);
               end else if (cnt_ff == CW'(5)) begin
                  cnt_in = CW'(6); emit_v = 1'b1; emit_b = sdh_pkg::BYTE_IDLE;
               end else if (d[7] && cnt_ff < CW'(14)) begin
                  cnt_in = cnt_ff + CW'(1); emit_v = 1'b1; emit_b = sdh_pkg::BYTE_IDLE;
               end else begin
                  resp_in = d;
                  unique case (ph_ff)
                     sdh_pkg::PH_CMD0: begin
                        if (d == 8'h01) begin
                           ph_in = sdh_pkg::PH_CMD8;
                        end else begin
                           att_in = att_dec;
                           if (spend_ok) begin
                              ph_in = sdh_pkg::PH_CMD0;
                           end else begin
                              fin_v = 1'b1; fin_s = sdh_pkg::ST_NO_IDLE;
                           end
                        end
                     end
                     sdh_pkg::PH_CMD8: begin
                        if (d != 8'h01) begin
                           fin_v = 1'b1; fin_s = sdh_pkg::ST_REJECTED;
                        end else begin
                           ph_in = sdh_pkg::PH_CMD8_TAIL; cnt_in = '0;
                           emit_v = 1'b1; emit_b = sdh_pkg::BYTE_IDLE;
                        end
                     end
                     sdh_pkg::PH_CMD55: begin
                        if (d[7:1] != 7'd0) begin
                           fin_v = 1'b1; fin_s = sdh_pkg::ST_REJECTED;
                        end else begin
                           ph_in = sdh_pkg::PH_ACMD41;
                        end
                     end
                     sdh_pkg::PH_ACMD41: begin
                        if (d[7:1] != 7'd0) begin
                           fin_v = 1'b1; fin_s = sdh_pkg::ST_REJECTED;
                        end else begin
                           att_in = att_dec;
                           if (spend_ok && d[0]) begin
                              ph_in = sdh_pkg::PH_CMD55;
                           end else if (d[0]) begin
                              fin_v = 1'b1; fin_s = sdh_pkg::ST_INIT_TOUT;
                           end else begin
                              ph_in = sdh_pkg::PH_CMD9;
                           end
                        end
                     end
                     sdh_pkg::PH_CMD9: begin
                        if (d != 8'd0) begin
                           fin_v = 1'b1; fin_s = sdh_pkg::ST_REJECTED;
                        end else begin
                           bad_in = 1'b0; ph_in = sdh_pkg::PH_CSD_TOKEN; cnt_in = '0;
                           att_in = reload_val; emit_v = 1'b1; emit_b = sdh_pkg::BYTE_IDLE;
                        end
                     end
                     sdh_pkg::PH_CMD17: begin
                        if (d != 8'd0) begin
                           fin_v = 1'b1; fin_s = sdh_pkg::ST_REJECTED;
                        end else begin
                           ph_in = sdh_pkg::PH_RD_TOKEN; cnt_in = '0;
                           att_in = reload_val; emit_v = 1'b1; emit_b = sdh_pkg::BYTE_IDLE;
                        end
                     end
                     default: begin
                        if (d != 8'd0) begin
                           fin_v = 1'b1; fin_s = sdh_pkg::ST_REJECTED;
                        end else begin
                           ph_in = sdh_pkg::PH_WR_DATA; cnt_in = '0;
                           emit_v = 1'b1; emit_b = sdh_pkg::TOKEN_DATA;
                        end
                     end
                  endcase
                  if (!fin_v && !emit_v) begin
                     cnt_in = '0; sel_in = 1'b1; emit_v = 1'b1;
                     emit_b = sdh_pkg::frame_byte(ph_in, 3'd0, sec_ff);
                  end
               end
            end
            sdh_pkg::PH_CMD8_TAIL: begin
               if (cnt_ff < CW'(3)) begin
                  cnt_in = cnt_ff + CW'(1); emit_v = 1'b1; emit_b = sdh_pkg::BYTE_IDLE;
               end else begin
                  att_in = reload_val; ph_in = sdh_pkg::PH_CMD55; cnt_in = '0;
                  sel_in = 1'b1; emit_v = 1'b1;
                  emit_b = sdh_pkg::frame_byte(sdh_pkg::PH_CMD55, 3'd0, sec_ff);
               end
            end
            sdh_pkg::PH_CSD_TOKEN, sdh_pkg::PH_RD_TOKEN: begin
               resp_in = d; att_in = att_dec;
               if (spend_ok && d == sdh_pkg::BYTE_IDLE) begin
                  emit_v = 1'b1; emit_b = sdh_pkg::BYTE_IDLE;
               end else if (d != sdh_pkg::TOKEN_DATA) begin
                  fin_v = 1'b1; fin_s = sdh_pkg::ST_TOKEN_ERR;
               end else begin
                  ph_in = (ph_ff == sdh_pkg::PH_CSD_TOKEN) ? sdh_pkg::PH_CSD_DATA
                                                           : sdh_pkg::PH_RD_DATA;
                  cnt_in = '0; emit_v = 1'b1; emit_b = sdh_pkg::BYTE_IDLE;
               end
            end
            sdh_pkg::PH_CSD_DATA: begin
               if (cnt_ff == CW'(5) && d[3:0] != block_size_log2) begin
                  bad_in = 1'b1;
               end
               if (cnt_ff < CW'(15)) begin
                  cnt_in = cnt_ff + CW'(1); emit_v = 1'b1; emit_b = sdh_pkg::BYTE_IDLE;
               end else if (bad_ff) begin
                  fin_v = 1'b1; fin_s = sdh_pkg::ST_SIZE_BAD;
               end else begin
                  ready_in = 1'b1; fin_v = 1'b1; fin_s = sdh_pkg::ST_OK;
               end
            end
            sdh_pkg::PH_RD_DATA: begin
               rv = 1'b1; rd_b = d; emit_v = 1'b1; emit_b = sdh_pkg::BYTE_IDLE;
               if (cnt_ff == LAST) begin
                  ph_in = sdh_pkg::PH_RD_CRC; cnt_in = '0;
               end else begin
                  cnt_in = cnt_ff + CW'(1);
               end
            end
            sdh_pkg::PH_RD_CRC: begin
               if (cnt_ff == '0) begin
                  cnt_in = CW'(1); emit_v = 1'b1; emit_b = sdh_pkg::BYTE_IDLE;
               end else begin
                  left_in = left_ff - 8'd1; sec_in = sec_ff + 32'd1;
                  if (left_in == 8'd0) begin
                     fin_v = 1'b1; fin_s = sdh_pkg::ST_OK;
                  end else begin
                     ph_in = sdh_pkg::PH_CMD17; cnt_in = '0; sel_in = 1'b1;
                     emit_v = 1'b1;
                     emit_b = sdh_pkg::frame_byte(sdh_pkg::PH_CMD17, 3'd0, sec_in);
                  end
               end
            end
            sdh_pkg::PH_WR_DATA: begin
               if (cnt_ff < FULL) begin
                  cnt_in = cnt_ff + CW'(1); emit_v = 1'b1; emit_b = buf_rd_data;
               end else begin
                  ph_in = sdh_pkg::PH_WR_RESP; cnt_in = '0; att_in = reload_val;
                  emit_v = 1'b1; emit_b = sdh_pkg::BYTE_IDLE;
               end
            end
            sdh_pkg::PH_WR_RESP: begin
               resp_in = d; att_in = att_dec;
               if (spend_ok && d == sdh_pkg::BYTE_IDLE) begin
                  emit_v = 1'b1; emit_b = sdh_pkg::BYTE_IDLE;
               end else if (d[3:0] == 4'h5) begin
                  ph_in = sdh_pkg::PH_WR_BUSY; cnt_in = '0; att_in = reload_val;
                  emit_v = 1'b1; emit_b = sdh_pkg::BYTE_IDLE;
               end else begin
                  fin_v = 1'b1; fin_s = sdh_pkg::ST_TOKEN_ERR;
               end
            end
            sdh_pkg::PH_WR_BUSY: begin
               resp_in = d; att_in = att_dec;
               if (spend_ok && d == 8'd0) begin
                  emit_v = 1'b1; emit_b = sdh_pkg::BYTE_IDLE;
               end else begin
                  fin_v = 1'b1;
                  fin_s = (d == sdh_pkg::BYTE_IDLE) ? sdh_pkg::ST_OK : sdh_pkg::ST_TOKEN_ERR;
               end
            end
            default: begin
            end
         endcase
      end else if (accept && ph_ff == sdh_pkg::PH_IDLE && action <= sdh_pkg::ACT_LOAD) begin
         if (action == sdh_pkg::ACT_LOAD) begin
            buf_wr_en = 1'b1;
            cnt_in = (cnt_ff >= LAST) ? '0 : cnt_ff + CW'(1);
         end else if (drive_index != 8'd0) begin
            fin_v = 1'b1; fin_s = sdh_pkg::ST_NOT_READY;
         end else if (action == sdh_pkg::ACT_INIT) begin
            ready_in = 1'b0; ph_in = sdh_pkg::PH_WAKE; cnt_in = '0; sel_in = 1'b0;
            emit_v = 1'b1; emit_b = sdh_pkg::BYTE_IDLE;
         end else if (!ready_ff) begin
            fin_v = 1'b1; fin_s = sdh_pkg::ST_NOT_READY;
         end else begin
            sec_in = sector_address;
            if (action == sdh_pkg::ACT_READ) begin
               left_in = sector_count;
            end
            if (action == sdh_pkg::ACT_READ && sector_count == 8'd0) begin
               fin_v = 1'b1; fin_s = sdh_pkg::ST_OK;
            end else begin
               ph_in = (action == sdh_pkg::ACT_READ) ? sdh_pkg::PH_CMD17
                                                     : sdh_pkg::PH_CMD24;
               cnt_in = '0; sel_in = 1'b1; emit_v = 1'b1;
               emit_b = sdh_pkg::frame_byte(ph_in, 3'd0, sector_address);
            end
         end
      end
      if (fin_v) begin
         ph_in = sdh_pkg::PH_IDLE; cnt_in = '0; sel_in = 1'b0;
      end
   end

   assign res_valid         = emit_v | fin_v;
   assign res.mosi_byte     = emit_v ? emit_b : 8'd0;
   assign res.mosi_valid    = emit_v;
   assign res.select_low    = emit_v & sel_in;
   assign res.read_byte     = rd_b;
   assign res.read_valid    = rv;
   assign res.done_res      = fin_v;
   assign res.status        = fin_v ? fin_s : sdh_pkg::ST_OK;
   assign res.card_response = resp_in;

   assign buf_wr_addr = cnt_ff[AW-1:0];
   assign buf_wr_data = data_byte;
   assign buf_rd_addr = (cnt_in < FULL) ? cnt_in[AW-1:0] : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff <= sdh_pkg::PH_IDLE;
         cnt_ff <= '0;
         att_ff <= '0;
         sec_ff <= '0;
         left_ff <= '0;
         ready_ff <= 1'b0;
         sel_ff <= 1'b0;
         bad_ff <= 1'b0;
         resp_ff <= '0;
      end else begin
         ph_ff <= ph_in;
         cnt_ff <= cnt_in;
         att_ff <= att_in;
         sec_ff <= sec_in;
         left_ff <= left_in;
         ready_ff <= ready_in;
         sel_ff <= sel_in;
         bad_ff <= bad_in;
         resp_ff <= resp_in;
      end
   end
endmodule
`default_nettype wire

### rtl/sd_card_spi_host_engine_top.sv
// A result beat is formed combinationally from its request beat and registered in the output stage.
// Throughput: one request beat per cycle while req_stall is low; the write buffer is read one beat ahead.
// A two-entry output stage lets a request enter while one result waits.
// Reset (synchronous, active high) idles the sequencer and empties the output stage.
// Buffer contents are not cleared by reset.
`timescale 1ns / 1ps
`default_nettype none
`include "sd_card_spi_host_engine_top_assert.svh"
module sd_card_spi_host_engine_top #(
   parameter int SECTOR_BYTES = sdh_pkg::SECTOR_BYTES_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [2:0]  req_action,
   input  wire logic [7:0]  req_drive_index,
   input  wire logic [31:0] req_sector_address,
   input  wire logic [7:0]  req_sector_count,
   input  wire logic [7:0]  req_data_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic      [7:0]  rsp_mosi_byte,
   output logic             rsp_mosi_valid,
   output logic             rsp_select_low,
   output logic      [7:0]  rsp_read_byte,
   output logic             rsp_read_valid,
   output logic             rsp_done_res,
   output logic      [2:0]  rsp_status,
   output logic      [7:0]  rsp_card_response,
   input  wire logic        csr_write_enable,
   input  wire logic [0:0]  csr_index,
   input  wire logic [15:0] csr_write_data
);
   localparam int AW = $clog2(SECTOR_BYTES);

   logic [15:0] limit_ff;
   logic [3:0]  blog2_ff;
   logic        accept, take, new_v;
   sdh_pkg::result_type new_r, main_ff, skid_ff;
   logic        main_v_ff, skid_v_ff;
   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [7:0]    wr_data, rd_data;

   assign req_stall = skid_v_ff;
   assign accept    = req_valid & ~req_stall;
   assign take      = main_v_ff & ~rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= sdh_pkg::ATTEMPT_LIMIT_RESET;
         blog2_ff <= sdh_pkg::BLOCK_LOG2_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            sdh_pkg::CSR_ATTEMPT_LIMIT: limit_ff <= csr_write_data;
            sdh_pkg::CSR_BLOCK_LOG2:    blog2_ff <= csr_write_data[3:0];
            default: begin
            end
         endcase
      end
   end

   sdh_ram #(.WIDTH(8), .DEPTH(SECTOR_BYTES)) u_buf (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   sdh_seq #(.SECTOR_BYTES(SECTOR_BYTES)) u_seq (
      .clock(clock), .reset(reset), .accept(accept),
      .action(req_action), .drive_index(req_drive_index),
      .sector_address(req_sector_address), .sector_count(req_sector_count),
      .data_byte(req_data_byte), .attempt_limit(limit_ff),
      .block_size_log2(blog2_ff), .buf_rd_data(rd_data),
      .buf_wr_en(wr_en), .buf_wr_addr(wr_addr), .buf_wr_data(wr_data),
      .buf_rd_addr(rd_addr), .res_valid(new_v), .res(new_r)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         main_v_ff <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (take && skid_v_ff) begin
         main_ff   <= skid_ff;
         skid_v_ff <= 1'b0;
      end else if (take || !main_v_ff) begin
         main_ff   <= new_r;
         main_v_ff <= new_v;
      end else if (new_v) begin
         skid_ff   <= new_r;
         skid_v_ff <= 1'b1;
      end
   end

   assign rsp_valid         = main_v_ff;
   assign rsp_mosi_byte     = main_ff.mosi_byte;
   assign rsp_mosi_valid    = main_ff.mosi_valid;
   assign rsp_select_low    = main_ff.select_low;
   assign rsp_read_byte     = main_ff.read_byte;
   assign rsp_read_valid    = main_ff.read_valid;
   assign rsp_done_res      = main_ff.done_res;
   assign rsp_status        = main_ff.status;
   assign rsp_card_response = main_ff.card_response;

   `SDH_ASSERT_IMPL(a_skid_implies_main, clock, reset, skid_v_ff, main_v_ff)
   `SDH_ASSERT_IMPL(a_done_no_mosi, clock, reset, main_v_ff && main_ff.done_res,
                    !main_ff.mosi_valid && !main_ff.select_low)
   `SDH_ASSERT_NEXT(a_stall_holds_result, clock, reset, main_v_ff && rsp_stall, main_v_ff)
   `SDH_ASSERT_ALWAYS(a_reset_empties, clock, reset, !rsp_valid && !req_stall)
endmodule
`default_nettype wire
